### rtl/rlsd_pkg.sv
// Shared types and codes for the run-length skip decoder.
// Holds the command and result word layouts; used by the top level and the testbench.
`timescale 1ns / 1ps

package rlsd_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_APPEND  = 2'd1;
    localparam logic [1:0] KIND_CONSUME = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] run_count;
        logic [DATA_W-1:0] run_value;
        logic [DATA_W-1:0] take_count;
    } rlsd_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              exhausted;
    } rlsd_res_t;

endpackage

### rtl/rlsd_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from rlsd_pkg at the point of use.
`timescale 1ns / 1ps

interface rlsd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rlsd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module rlsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/run_length_skip_decoder_unit.sv
// Top level of the run-length skip decoder: run table in two RAMs, walk control, result register.
// Depends on rlsd_pkg, rlsd_chan_if and rlsd_ram.
`timescale 1ns / 1ps

// Holds up to MAX_RUNS (count, value) runs and consumes the decoded sequence on request.
// A clear or append word is taken while the unit is idle. A consume word walks the count
// RAM past each run it uses up, reading one entry per cycle, and then loads the result
// register once that register is free. An exhausted table skips the walk. One command
// word is in flight at a time; a finished result waits in its own register, so the next
// command can start while the previous result is still unread. The RAMs need no clearing
// after reset: only entries already appended are ever used.
module run_length_skip_decoder_unit
    import rlsd_pkg::*;
#(
    parameter int MAX_RUNS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    rlsd_chan_if.sink   cmd,
    rlsd_chan_if.source res
);

    localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RUNS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [DATA_W-1:0] need_reg, need_next;
    logic [DATA_W-1:0] pend_value_reg, pend_value_next;
    logic              pend_exh_reg, pend_exh_next;
    logic              res_valid_reg, res_valid_next;
    rlsd_res_t         res_data_reg, res_data_next;

    logic              cmd_fire;
    logic              res_free;
    logic [CNT_W-1:0]  cursor_inc;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] rem_wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rem_rd_data;
    logic [DATA_W-1:0] val_rd_data;
    logic              val_wr_en;

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign res_free    = !res_valid_reg || res.ready;
    assign cursor_inc  = cursor_reg + CNT_ONE;
    assign res.valid   = res_valid_reg;
    assign res.payload = res_data_reg;

    // Speculatively read the next entry while walking.
    assign rd_addr = (state_reg == ST_WALK) ? cursor_inc[IDX_W-1:0] : cursor_reg[IDX_W-1:0];

    rlsd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_RUNS)) u_rem_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rem_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rem_rd_data)
    );

    rlsd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_RUNS)) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (total_reg[IDX_W-1:0]),
        .wr_data (cmd.payload.run_value),
        .rd_addr (rd_addr),
        .rd_data (val_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        cursor_next     = cursor_reg;
        need_next       = need_reg;
        pend_value_next = pend_value_reg;
        pend_exh_next   = pend_exh_reg;
        res_valid_next  = res_valid_reg;
        res_data_next   = res_data_reg;
        wr_en           = 1'b0;
        val_wr_en       = 1'b0;
        wr_addr         = total_reg[IDX_W-1:0];
        rem_wr_data     = cmd.payload.run_count;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.payload.kind)
                        KIND_CLEAR:
                        begin
                            total_next  = '0;
                            cursor_next = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (total_reg < CNT_MAX)
                            begin
                                wr_en      = 1'b1;
                                val_wr_en  = 1'b1;
                                total_next = total_reg + CNT_ONE;
                            end
                        end
                        KIND_CONSUME:
                        begin
                            need_next = cmd.payload.take_count;
                            if (cursor_reg < total_reg)
                            begin
                                state_next = ST_WALK;
                            end
                            else
                            begin
                                pend_value_next = '0;
                                pend_exh_next   = 1'b1;
                                state_next      = ST_FIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (rem_rd_data < need_reg)
                begin
                    // Use up this run and advance.
                    need_next   = need_reg - rem_rd_data;
                    cursor_next = cursor_inc;
                    if (cursor_inc >= total_reg)
                    begin
                        pend_value_next = '0;
                        pend_exh_next   = 1'b1;
                        state_next      = ST_FIN;
                    end
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_addr         = cursor_reg[IDX_W-1:0];
                    rem_wr_data     = rem_rd_data - need_reg;
                    pend_value_next = val_rd_data;
                    pend_exh_next   = 1'b0;
                    state_next      = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_free)
                begin
                    res_valid_next          = 1'b1;
                    res_data_next.value     = pend_value_reg;
                    res_data_next.exhausted = pend_exh_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            cursor_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cursor_reg    <= cursor_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        pend_value_reg <= pend_value_next;
        pend_exh_reg   <= pend_exh_next;
        res_data_reg   <= res_data_next;
    end

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_MAX)
        else $error("run count above table size");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= total_reg)
        else $error("cursor past end of table");

    a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cursor_reg < total_reg))
        else $error("walk outside filled entries");

    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.exhausted) |-> (res_data_reg.value == '0))
        else $error("exhausted result carries a value");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.payload.kind == KIND_APPEND && total_reg == CNT_MAX)
        |=> (total_reg == CNT_MAX))
        else $error("append into full table changed run count");
`endif

endmodule

### dv/tb_top.sv
// Testbench for run_length_skip_decoder_unit: directed rows, then random run tables, takes and noise words.
// Checks each result word against an in-bench decode of the run table or a row's typed result.
// Depends on rlsd_pkg, rlsd_chan_if and the top level.
`timescale 1ns / 1ps

module tb_top
    import rlsd_pkg::*;
();

    localparam int          RUN_SLOTS   = 64;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam int          ITEM_TARGET = 1350;
    localparam int          CYCLE_LIMIT = 800000;
    localparam int          HOLD_CYCLES = 320;

    typedef struct {
        rlsd_cmd_t cmd;
        bit        typed_ok;
        rlsd_res_t typed_res;
    } opening_row_t;

    logic clk;
    logic rst_n;

    rlsd_chan_if #(.payload_t(rlsd_cmd_t)) cmd_if ();
    rlsd_chan_if #(.payload_t(rlsd_res_t)) res_if ();

    run_length_skip_decoder_unit #(
        .MAX_RUNS(RUN_SLOTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    logic [DATA_W-1:0] run_left [RUN_SLOTS];
    logic [DATA_W-1:0] run_val  [RUN_SLOTS];
    int unsigned       runs_held;
    int unsigned       walk_pos;

    rlsd_res_t    decode_due [$];
    opening_row_t opening_rows [$];

    int err_count;
    int items_sent;
    int clears_sent;
    int appends_sent;
    int takes_sent;
    int unused_sent;
    int appends_dropped;
    int results_seen;
    int exhausted_seen;
    int burst_left;
    int hold_requests;
    int hold_served;
    int hold_left;
    int rx_tick;
    int cycle_count;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit decode_step(input rlsd_cmd_t c, output rlsd_res_t r);
        logic [DATA_W-1:0] need;
        r = '0;
        case (c.kind)
            KIND_CLEAR:
            begin
                runs_held = 0;
                walk_pos  = 0;
                return 1'b0;
            end
            KIND_APPEND:
            begin
                if (runs_held < RUN_SLOTS)
                begin
                    run_left[runs_held] = c.run_count;
                    run_val[runs_held]  = c.run_value;
                    runs_held++;
                end
                else
                    appends_dropped++;
                return 1'b0;
            end
            KIND_CONSUME:
            begin
                need = c.take_count;
                while (walk_pos < runs_held && run_left[walk_pos] < need)
                begin
                    need -= run_left[walk_pos];
                    run_left[walk_pos] = '0;
                    walk_pos++;
                end
                if (walk_pos < runs_held)
                begin
                    run_left[walk_pos] -= need;
                    r.value     = run_val[walk_pos];
                    r.exhausted = 1'b0;
                end
                else
                begin
                    r.value     = '0;
                    r.exhausted = 1'b1;
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_word(input rlsd_cmd_t c, input bit typed_ok, input rlsd_res_t typed_res);
        rlsd_res_t r;
        bit        has;
        @(negedge clk);
        if (burst_left == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        has = decode_step(c, r);
        if (has)
            decode_due.push_back(typed_ok ? typed_res : r);
        case (c.kind)
            KIND_CLEAR:   clears_sent++;
            KIND_APPEND:  appends_sent++;
            KIND_CONSUME: takes_sent++;
            default:      unused_sent++;
        endcase
        if (c.kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic push_cmd(input logic [1:0] kind, input logic [DATA_W-1:0] cnt,
                            input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] take);
        rlsd_cmd_t c;
        c.kind       = kind;
        c.run_count  = cnt;
        c.run_value  = val;
        c.take_count = take;
        send_word(c, 1'b0, '0);
    endtask

    function automatic void add_row(input logic [1:0] kind, input logic [DATA_W-1:0] cnt,
                                    input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] take,
                                    input bit typed_ok, input logic [DATA_W-1:0] res_val,
                                    input bit res_exh);
        opening_row_t row;
        row.cmd.kind              = kind;
        row.cmd.run_count         = cnt;
        row.cmd.run_value         = val;
        row.cmd.take_count        = take;
        row.typed_ok              = typed_ok;
        row.typed_res.value       = res_val;
        row.typed_res.exhausted   = res_exh;
        opening_rows.push_back(row);
    endfunction

    function automatic logic [DATA_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 3)
            return '0;
        if (r < 13)
            return $urandom_range(1, 6);
        if (r == 13)
            return $urandom_range(7, 1000);
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] pick_take();
        int unsigned       r;
        logic [DATA_W-1:0] t;
        r = $urandom_range(0, 15);
        if (r < 12)
            return $urandom_range(1, 6);
        if (r < 14)
            return $urandom_range(7, 40);
        t = $urandom;
        return (t == 0) ? 1 : t;
    endfunction

    task automatic drain_results();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (decode_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic well_formed_run();
        int n;
        int m;
        if ($urandom_range(0, 3) != 0)
            push_cmd(KIND_CLEAR, $urandom, $urandom, $urandom);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            push_cmd(KIND_APPEND, pick_count(), $urandom, $urandom);
        m = $urandom_range(1, 10);
        for (int j = 0; j < m; j++)
        begin
            if ($urandom_range(0, 5) == 0)
                push_cmd(KIND_APPEND, pick_count(), $urandom, $urandom);
            push_cmd(KIND_CONSUME, $urandom, $urandom, pick_take());
        end
    endtask

    task automatic noise_run();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            push_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    endtask

    task automatic broken_run();
        if ($urandom_range(0, 1) == 0)
        begin
            push_cmd(KIND_CLEAR, $urandom, $urandom, $urandom);
            repeat ($urandom_range(1, 4))
                push_cmd(KIND_CONSUME, $urandom, $urandom, pick_take());
        end
        else
        begin
            repeat ($urandom_range(66, 72))
                push_cmd(KIND_APPEND, $urandom_range(0, 3), $urandom, $urandom);
            repeat ($urandom_range(1, 6))
                push_cmd(KIND_CONSUME, $urandom, $urandom, pick_take());
        end
    endtask

    task automatic backpressure_run();
        push_cmd(KIND_CLEAR, '0, '0, '0);
        repeat (4)
            push_cmd(KIND_APPEND, 1000, $urandom, '0);
        hold_requests++;
        repeat (24)
            push_cmd(KIND_CONSUME, '0, '0, $urandom_range(1, 5));
    endtask

    // result side: stall pattern plus long hold-off on request
    initial
    begin
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                case ((rx_tick / 97) % 4)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= 1'($urandom_range(0, 1));
                    2:       res_if.ready <= (rx_tick % 3 == 0);
                    default: res_if.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        rlsd_res_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (res_if.payload.exhausted)
                exhausted_seen++;
            if (decode_due.size() == 0)
            begin
                $error("result word with nothing expected: value %h exhausted %b",
                       res_if.payload.value, res_if.payload.exhausted);
                err_count++;
            end
            else
            begin
                want = decode_due.pop_front();
                if (res_if.payload.value !== want.value)
                begin
                    $error("value: expected %h, actual %h", want.value, res_if.payload.value);
                    err_count++;
                end
                if (res_if.payload.exhausted !== want.exhausted)
                begin
                    $error("exhausted: expected %b, actual %b",
                           want.exhausted, res_if.payload.exhausted);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        int seq_no;
        int pick;
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        runs_held      = 0;
        walk_pos       = 0;

        add_row(KIND_CONSUME, '0, '0, 32'd1, 1'b1, '0, 1'b1);
        add_row(KIND_CONSUME, '0, '0, 32'd0, 1'b1, '0, 1'b1);
        add_row(KIND_UNUSED, '1, '1, '1, 1'b0, '0, 1'b0);
        add_row(KIND_APPEND, 32'd0, 32'hA5A5_A5A5, '0, 1'b0, '0, 1'b0);
        add_row(KIND_APPEND, '1, '1, '0, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, 32'd0, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, 32'd1, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, '1, 1'b1, '0, 1'b1);
        add_row(KIND_APPEND, 32'd1, 32'h5A5A_5A5A, '0, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, 32'd1, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, 32'd1, 1'b1, '0, 1'b1);
        add_row(KIND_CLEAR, '1, '1, '1, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, '1, 1'b1, '0, 1'b1);
        add_row(KIND_APPEND, 32'd3, 32'h0000_0001, '0, 1'b0, '0, 1'b0);
        add_row(KIND_APPEND, 32'd0, 32'h8000_0000, '0, 1'b0, '0, 1'b0);
        add_row(KIND_APPEND, 32'd2, 32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, 32'd3, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, 32'd2, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, 32'd1, 1'b1, '0, 1'b1);
        add_row(KIND_APPEND, 32'h8000_0000, '1, '0, 1'b0, '0, 1'b0);
        add_row(KIND_CONSUME, '0, '0, 32'h8000_0000, 1'b0, '0, 1'b0);
        add_row(KIND_CLEAR, '0, '0, '0, 1'b0, '0, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening_rows[i])
            send_word(opening_rows[i].cmd, opening_rows[i].typed_ok, opening_rows[i].typed_res);

        seq_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            seq_no++;
            if (seq_no == 3 || seq_no == 70)
                backpressure_run();
            if (seq_no == 40 || seq_no == 90)
                drain_results();
            pick = $urandom_range(0, 9);
            if (pick < 7)
                well_formed_run();
            else if (pick < 9)
                noise_run();
            else
                broken_run();
        end

        drain_results();
        repeat (RUN_SLOTS + 20) @(posedge clk);

        $display("Summary: %0d words sent (%0d clear, %0d append, %0d consume), %0d unused kind",
                 items_sent, clears_sent, appends_sent, takes_sent, unused_sent);
        $display("Summary: %0d results checked, %0d exhausted, %0d appends dropped on full table",
                 results_seen, exhausted_seen, appends_dropped);
        if (err_count == 0 && decode_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
